/* hdl/lnac_pkg.sv */
// Shared types, constants and helpers for the noise audio channel.
`default_nettype none

package lnac_pkg;

   localparam int unsigned BASE_ADDRESS_DEFAULT = 65312;

   localparam int unsigned CMD_W     = 3;
   localparam int unsigned ADDR_W    = 16;
   localparam int unsigned BYTE_W    = 8;
   localparam int unsigned LEVEL_W   = 4;
   localparam int unsigned LFSR_W    = 16;
   localparam int unsigned ACC_W     = 24;
   localparam int unsigned PERIOD_W  = 22;
   localparam int unsigned ENVCNT_W  = 3;

   localparam logic [LFSR_W-1:0]  LFSR_SEED     = 16'hFFFF;
   localparam logic [ACC_W-1:0]   ACC_MAX       = 24'hFFFFFF;
   localparam logic [BYTE_W:0]    LENGTH_LIMIT  = 9'd64;
   localparam logic [LEVEL_W-1:0] LEVEL_MAX     = 4'd15;

   typedef enum logic [CMD_W-1:0] {
      CMD_WRITE    = 3'd0,
      CMD_READ     = 3'd1,
      CMD_CYCLES   = 3'd2,
      CMD_LEN_TICK = 3'd3,
      CMD_ENV_TICK = 3'd4
   } cmd_type;

   typedef enum logic [1:0] {
      REG_LENGTH    = 2'd0,
      REG_ENVELOPE  = 2'd1,
      REG_FREQUENCY = 2'd2,
      REG_CONTROL   = 2'd3
   } reg_offset_type;

   localparam logic [6:0] DIVISOR_TABLE [8] = '{
      7'd8, 7'd16, 7'd32, 7'd48, 7'd64, 7'd80, 7'd96, 7'd112
   };

   // Divisor scaled by the shift field of the frequency register.
   function automatic logic [PERIOD_W-1:0] lfsr_period(input logic [BYTE_W-1:0] freq);
      logic [PERIOD_W-1:0] base;
      base = PERIOD_W'(DIVISOR_TABLE[freq[2:0]]);
      return base << freq[7:4];
   endfunction

endpackage

`default_nettype wire

/* hdl/lfsr_noise_audio_channel.sv */
// Noise audio channel: register file, LFSR clocking, length and envelope logic.
`default_nettype none

//  channel | ports      | tdata (lsb first)                      | tuser
//  --------+------------+----------------------------------------+-------------
//  input   | req_*      | address[15:0] write_data[7:0] cycles[7:0] | command[2:0]
//  result  | rsp_*      | sample[3:0] read_data[7:0] claimed channel_on | -
//
//  One transfer in per cycle, one result out per cycle, sustained while the
//  result is not stalled. An item is held in the input register and is applied
//  to the channel state as it moves into the result register.
//  Synchronous active-high reset initialises the channel state and empties both stages.
//  A stalled result holds; the input register still refills while it is empty
//  or while the result stage is empty or being drained.

module lfsr_noise_audio_channel #(
   parameter int unsigned BASE_ADDRESS = lnac_pkg::BASE_ADDRESS_DEFAULT
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_tvalid,
   output logic                              req_tready,
   input  wire logic [31:0]                  req_tdata,  // address, write_data, cycles
   input  wire logic [lnac_pkg::CMD_W-1:0]   req_tuser,  // command
   output logic                              rsp_tvalid,
   input  wire logic                         rsp_tready,
   output logic [15:0]                       rsp_tdata   // sample, read_data, claimed,
                                                         // channel_on, 2'b0
);
   import lnac_pkg::*;

   localparam logic [ADDR_W-1:0] BASE = ADDR_W'(BASE_ADDRESS);

   // ---- input stage ----
   logic                 in_valid_ff, in_valid_in;
   logic [CMD_W-1:0]     cmd_ff;
   logic [ADDR_W-1:0]    addr_ff;
   logic [BYTE_W-1:0]    wdata_ff;
   logic [BYTE_W-1:0]    cycles_ff;

   // ---- result stage ----
   logic                 out_valid_ff, out_valid_in;
   logic [LEVEL_W-1:0]   sample_ff, sample_in;
   logic [BYTE_W-1:0]    rdata_ff, rdata_in;
   logic                 claimed_ff, claimed_in;

   // ---- channel state ----
   logic [LFSR_W-1:0]    lfsr_ff, lfsr_in;
   logic                 enabled_ff, enabled_in;
   logic [LEVEL_W-1:0]   level_ff, level_in;
   logic                 env_active_ff, env_active_in;
   logic [ENVCNT_W-1:0]  env_cnt_ff, env_cnt_in;
   logic [BYTE_W-1:0]    len_cnt_ff, len_cnt_in;
   logic [ACC_W-1:0]     acc_ff, acc_in;
   logic [BYTE_W-1:0]    env_reg_ff, env_reg_in;
   logic [PERIOD_W-1:0]  period_ff, period_in;   // decoded from frequency register
   logic                 short_mode_ff, short_mode_in; // frequency bit 3
   logic                 len_en_ff, len_en_in;   // control bit 6

   logic                 advance;

   // item moves into the result stage when that stage is free or draining
   assign advance     = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready  = !in_valid_ff || advance;
   assign in_valid_in = req_tready ? req_tvalid : in_valid_ff;
   assign out_valid_in = advance ? 1'b1 : (out_valid_ff && !rsp_tready);

   // ---- item processing ----
   logic [ADDR_W-1:0]    offset;
   logic                 reg_hit;
   logic [ACC_W:0]       acc_sum;
   logic [ACC_W-1:0]     acc_sat;
   logic [ACC_W:0]       acc_diff;
   logic                 lfsr_fb;
   logic [LFSR_W-1:0]    lfsr_step;
   logic [BYTE_W:0]      len_next;
   logic [ENVCNT_W-1:0]  env_cnt_inc;
   logic [ENVCNT_W-1:0]  pace;

   always_comb begin
      offset   = addr_ff - BASE;
      reg_hit  = (offset[ADDR_W-1:2] == '0);

      acc_sum  = {1'b0, acc_ff} + (ACC_W+1)'(cycles_ff);
      acc_sat  = acc_sum[ACC_W] ? ACC_MAX : acc_sum[ACC_W-1:0];
      acc_diff = {1'b0, acc_sat} - (ACC_W+1)'(period_ff);

      // feedback into bit 14 (and bit 6 in short mode) after the shift
      lfsr_fb   = lfsr_ff[0] ^ lfsr_ff[1];
      lfsr_step = {1'b0, lfsr_fb, lfsr_ff[14:1]};
      if (short_mode_ff) begin
         lfsr_step[6] = lfsr_fb;
      end

      len_next    = {1'b0, len_cnt_ff} + 9'd1;
      env_cnt_inc = env_cnt_ff + 3'd1;
      pace        = env_reg_ff[2:0];

      lfsr_in       = lfsr_ff;
      enabled_in    = enabled_ff;
      level_in      = level_ff;
      env_active_in = env_active_ff;
      env_cnt_in    = env_cnt_ff;
      len_cnt_in    = len_cnt_ff;
      acc_in        = acc_ff;
      env_reg_in    = env_reg_ff;
      period_in     = period_ff;
      short_mode_in = short_mode_ff;
      len_en_in     = len_en_ff;
      rdata_in      = '0;
      claimed_in    = 1'b0;

      case (cmd_type'(cmd_ff))
         CMD_WRITE: begin
            if (reg_hit) begin
               case (reg_offset_type'(offset[1:0]))
                  REG_LENGTH: begin
                     len_cnt_in = wdata_ff;
                     claimed_in = 1'b1;
                  end
                  REG_ENVELOPE: begin
                     env_reg_in = wdata_ff;
                  end
                  REG_FREQUENCY: begin
                     period_in     = lfsr_period(wdata_ff);
                     short_mode_in = wdata_ff[3];
                  end
                  REG_CONTROL: begin
                     len_en_in  = wdata_ff[6];
                     claimed_in = 1'b1;
                     if (wdata_ff[7]) begin
                        // trigger
                        enabled_in    = 1'b1;
                        level_in      = env_reg_ff[7:4];
                        env_active_in = 1'b1;
                        lfsr_in       = LFSR_SEED;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         CMD_READ: begin
            if (reg_hit && (reg_offset_type'(offset[1:0]) == REG_CONTROL)) begin
               rdata_in   = {1'b0, len_en_ff, 6'b0};
               claimed_in = 1'b1;
            end
         end
         CMD_CYCLES: begin
            if (enabled_ff) begin
               if (!acc_diff[ACC_W]) begin
                  acc_in  = acc_diff[ACC_W-1:0];
                  lfsr_in = lfsr_step;
               end else begin
                  acc_in  = acc_sat;
               end
            end
         end
         CMD_LEN_TICK: begin
            if (len_en_ff) begin
               if (len_next >= LENGTH_LIMIT) begin
                  len_cnt_in = '0;
                  enabled_in = 1'b0;
               end else begin
                  len_cnt_in = len_next[BYTE_W-1:0];
               end
            end
         end
         CMD_ENV_TICK: begin
            if (env_reg_ff[7:3] == '0) begin
               enabled_in = 1'b0;
            end else if (env_cnt_inc < pace) begin
               env_cnt_in = env_cnt_inc;
            end else if ((pace == '0) || !env_active_ff) begin
               env_cnt_in = '0;
            end else begin
               env_cnt_in = env_cnt_inc - pace;
               if (env_reg_ff[3]) begin
                  if (level_ff == LEVEL_MAX) begin
                     env_active_in = 1'b0;
                  end else begin
                     level_in = level_ff + 4'd1;
                  end
               end else begin
                  if (level_ff == '0) begin
                     env_active_in = 1'b0;
                  end else begin
                     level_in = level_ff - 4'd1;
                  end
               end
            end
         end
         default: begin
         end
      endcase

      sample_in = (enabled_in && !lfsr_in[0]) ? level_in : '0;
   end

   // ---- registers ----
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         lfsr_ff       <= LFSR_SEED;
         enabled_ff    <= 1'b0;
         level_ff      <= '0;
         env_active_ff <= 1'b0;
         env_cnt_ff    <= '0;
         len_cnt_ff    <= '0;
         acc_ff        <= '0;
         env_reg_ff    <= '0;
         period_ff     <= lfsr_period('0);
         short_mode_ff <= 1'b0;
         len_en_ff     <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            lfsr_ff       <= lfsr_in;
            enabled_ff    <= enabled_in;
            level_ff      <= level_in;
            env_active_ff <= env_active_in;
            env_cnt_ff    <= env_cnt_in;
            len_cnt_ff    <= len_cnt_in;
            acc_ff        <= acc_in;
            env_reg_ff    <= env_reg_in;
            period_ff     <= period_in;
            short_mode_ff <= short_mode_in;
            len_en_ff     <= len_en_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         cmd_ff    <= req_tuser;
         addr_ff   <= req_tdata[15:0];
         wdata_ff  <= req_tdata[23:16];
         cycles_ff <= req_tdata[31:24];
      end
      if (advance) begin
         sample_ff  <= sample_in;
         rdata_ff   <= rdata_in;
         claimed_ff <= claimed_in;
      end
   end

   logic chan_on_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         chan_on_ff <= enabled_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {2'b00, chan_on_ff, claimed_ff, rdata_ff, sample_ff};

   // ---- checks ----
   a_sample_needs_on: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tdata[3:0] != '0)) |-> rsp_tdata[13])
      else $error("sample nonzero while channel off");

   a_read_needs_claim: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tdata[11:4] != '0)) |-> rsp_tdata[12])
      else $error("read data without claim");

   a_acc_idle_when_off: assert property (@(posedge clock) disable iff (reset)
      !enabled_ff |=> $stable(acc_ff))
      else $error("accumulator moved while channel off");

   a_sample_follows_state: assert property (@(posedge clock) disable iff (reset)
      advance |=> (sample_ff == ((enabled_ff && !lfsr_ff[0]) ? level_ff : '0)))
      else $error("result sample disagrees with channel state");

endmodule

`default_nettype wire
